>>> rtl/lidar_scan_response_decoder_assert.svh
// Assertion macros used by the decoder back end (lsrd_back).
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LIDAR_SCAN_RESPONSE_DECODER_ASSERT_SVH
`define LIDAR_SCAN_RESPONSE_DECODER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define LSRD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define LSRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lsrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrd_pkg
// Types, codes and constants of the scan response decoder.
// ----------------------------------------------------------------------------
package lsrd_pkg;

  localparam int MAX_VALUES  = 1024;
  localparam int CNT_W       = $clog2(MAX_VALUES + 1);
  localparam int POS_W       = 11;
  localparam int DIST_W      = 12;
  localparam int SIX_W       = 6;
  localparam int TAG_LEN     = 5;
  localparam int TAG_W       = $clog2(TAG_LEN);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_OFFSET = 8'h30;
  localparam logic [7:0] LF_CHAR     = 8'h0A;
  localparam logic [7:0] STATUS_TAG [TAG_LEN] = '{8'h0A, 8'h39, 8'h39, 8'h62, 8'h0A};

  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_START   = 2'd2;

  localparam logic [1:0] KIND_DIST = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_SKIP,
    PH_RECORD,
    PH_FAILED
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CHAR,
    OP_LF,
    OP_TIMEOUT,
    OP_START
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DIST_W-1:0] distance;
    logic [POS_W-1:0]  position;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [TAG_LEN-1:0] tag_hit;
    logic [SIX_W-1:0]   value;
  } entry_t;

endpackage

>>> rtl/lsrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrd_front
// Accepts input items, classifies them and precomputes tag hits and the
// six-bit character value for the back end.
// ----------------------------------------------------------------------------
module lsrd_front (
  input  logic               byte_valid,
  output logic               byte_stall,
  input  lsrd_pkg::in_item_t byte_item,
  input  logic               q_full,
  output logic               q_push,
  output lsrd_pkg::entry_t   q_entry
);

  lsrd_pkg::op_t              op;
  logic [7:0]                 diff;
  logic [lsrd_pkg::TAG_LEN-1:0] hits;

  always_comb begin
    case (byte_item.func)
      lsrd_pkg::FUNC_BYTE: begin
        op = (byte_item.rx_byte == lsrd_pkg::LF_CHAR) ? lsrd_pkg::OP_LF : lsrd_pkg::OP_CHAR;
      end
      lsrd_pkg::FUNC_TIMEOUT: op = lsrd_pkg::OP_TIMEOUT;
      lsrd_pkg::FUNC_START:   op = lsrd_pkg::OP_START;
      default:                op = lsrd_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < lsrd_pkg::TAG_LEN; i++) begin
      hits[i] = (byte_item.rx_byte == lsrd_pkg::STATUS_TAG[i]);
    end
  end

  assign diff       = byte_item.rx_byte - lsrd_pkg::CHAR_OFFSET;
  assign byte_stall = q_full;
  // drop unused function codes here
  assign q_push     = byte_valid && !q_full && (op != lsrd_pkg::OP_NONE);

  always_comb begin
    q_entry.op      = op;
    q_entry.tag_hit = hits;
    q_entry.value   = diff[lsrd_pkg::SIX_W-1:0];
  end

endmodule

>>> rtl/lsrd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrd_queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module lsrd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lsrd_pkg::entry_t push_entry,
  output logic             full,
  output logic             nonempty,
  input  logic             pop,
  output lsrd_pkg::entry_t head
);

  lsrd_pkg::entry_t                slots [lsrd_pkg::QUEUE_DEPTH];
  logic [lsrd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [lsrd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [lsrd_pkg::QCNT_W-1:0]     count;

  assign full     = (count == lsrd_pkg::QCNT_W'(lsrd_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lsrd_pkg::QPTR_W'(lsrd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lsrd_pkg::QPTR_W'(lsrd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/lsrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrd_back
// Scan state machine: tag match, header skip, checksum drop, pairing of
// characters into distances, timeouts, and the registered result stage.
// ----------------------------------------------------------------------------
`include "lidar_scan_response_decoder_assert.svh"

module lsrd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nonempty,
  input  lsrd_pkg::entry_t    q_head,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_stall,
  output lsrd_pkg::out_item_t result_item
);

  lsrd_pkg::phase_t                phase, phase_next;
  logic [lsrd_pkg::TAG_W-1:0]      tag_pos, tag_pos_next;
  logic [lsrd_pkg::SIX_W-1:0]      pending_char, pending_char_next;
  logic                            pending_valid, pending_valid_next;
  logic [lsrd_pkg::SIX_W-1:0]      half_char, half_char_next;
  logic                            half_valid, half_valid_next;
  logic                            prev_was_lf, prev_was_lf_next;
  logic [lsrd_pkg::CNT_W-1:0]      value_count, value_count_next;
  logic                            emit;
  lsrd_pkg::out_item_t             emit_item;
  logic                            out_free;

  assign out_free = !result_valid || !result_stall;
  assign q_pop    = q_nonempty && out_free;

  always_comb begin
    phase_next         = phase;
    tag_pos_next       = tag_pos;
    pending_char_next  = pending_char;
    pending_valid_next = pending_valid;
    half_char_next     = half_char;
    half_valid_next    = half_valid;
    prev_was_lf_next   = prev_was_lf;
    value_count_next   = value_count;
    emit               = 1'b0;
    emit_item          = '0;

    if (q_pop) begin
      case (q_head.op)
        lsrd_pkg::OP_START: begin
          tag_pos_next       = '0;
          pending_char_next  = '0;
          pending_valid_next = 1'b0;
          half_char_next     = '0;
          half_valid_next    = 1'b0;
          prev_was_lf_next   = 1'b0;
          value_count_next   = '0;
          phase_next         = lsrd_pkg::PH_TAG;
        end
        lsrd_pkg::OP_TIMEOUT: begin
          if (phase inside {lsrd_pkg::PH_TAG, lsrd_pkg::PH_SKIP, lsrd_pkg::PH_RECORD}) begin
            tag_pos_next       = '0;
            pending_char_next  = '0;
            pending_valid_next = 1'b0;
            half_char_next     = '0;
            half_valid_next    = 1'b0;
            prev_was_lf_next   = 1'b0;
            value_count_next   = '0;
            phase_next         = lsrd_pkg::PH_FAILED;
            emit               = 1'b1;
            emit_item.kind     = lsrd_pkg::KIND_FAIL;
            emit_item.last     = 1'b1;
          end
        end
        lsrd_pkg::OP_CHAR, lsrd_pkg::OP_LF: begin
          case (phase)
            lsrd_pkg::PH_TAG: begin
              if (q_head.tag_hit[tag_pos]) begin
                if (tag_pos == lsrd_pkg::TAG_W'(lsrd_pkg::TAG_LEN - 1)) begin
                  tag_pos_next = '0;
                  phase_next   = lsrd_pkg::PH_SKIP;
                end else begin
                  tag_pos_next = tag_pos + 1'b1;
                end
              end else begin
                tag_pos_next = '0;
              end
            end
            lsrd_pkg::PH_SKIP: begin
              if (q_head.op == lsrd_pkg::OP_LF) begin
                phase_next       = lsrd_pkg::PH_RECORD;
                value_count_next = '0;
              end
            end
            lsrd_pkg::PH_RECORD: begin
              if (q_head.op == lsrd_pkg::OP_LF) begin
                if (prev_was_lf) begin
                  emit               = 1'b1;
                  emit_item.kind     = lsrd_pkg::KIND_DONE;
                  emit_item.position = lsrd_pkg::POS_W'(value_count);
                  emit_item.last     = 1'b1;
                  tag_pos_next       = '0;
                  pending_char_next  = '0;
                  pending_valid_next = 1'b0;
                  half_char_next     = '0;
                  half_valid_next    = 1'b0;
                  prev_was_lf_next   = 1'b0;
                  value_count_next   = '0;
                  phase_next         = lsrd_pkg::PH_IDLE;
                end else begin
                  // drop the line checksum
                  pending_valid_next = 1'b0;
                  prev_was_lf_next   = 1'b1;
                end
              end else begin
                if (pending_valid &&
                    (value_count < lsrd_pkg::CNT_W'(lsrd_pkg::MAX_VALUES))) begin
                  if (!half_valid) begin
                    half_char_next  = pending_char;
                    half_valid_next = 1'b1;
                  end else begin
                    emit               = 1'b1;
                    emit_item.kind     = lsrd_pkg::KIND_DIST;
                    emit_item.distance = {half_char, pending_char};
                    emit_item.position = lsrd_pkg::POS_W'(value_count);
                    value_count_next   = value_count + 1'b1;
                    half_valid_next    = 1'b0;
                  end
                end
                pending_char_next  = q_head.value;
                pending_valid_next = 1'b1;
                prev_was_lf_next   = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lsrd_pkg::PH_IDLE;
      tag_pos       <= '0;
      pending_char  <= '0;
      pending_valid <= 1'b0;
      half_char     <= '0;
      half_valid    <= 1'b0;
      prev_was_lf   <= 1'b0;
      value_count   <= '0;
      result_valid  <= 1'b0;
    end else begin
      phase         <= phase_next;
      tag_pos       <= tag_pos_next;
      pending_char  <= pending_char_next;
      pending_valid <= pending_valid_next;
      half_char     <= half_char_next;
      half_valid    <= half_valid_next;
      prev_was_lf   <= prev_was_lf_next;
      value_count   <= value_count_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_item <= emit_item;
    end
  end

  `LSRD_ASSERT_ALWAYS(a_count_cap, value_count <= lsrd_pkg::CNT_W'(lsrd_pkg::MAX_VALUES), "value count beyond capacity")
  `LSRD_ASSERT_ALWAYS(a_tag_pos_range, tag_pos < lsrd_pkg::TAG_W'(lsrd_pkg::TAG_LEN), "tag position out of range")
  `LSRD_ASSERT_ALWAYS(a_last_on_end, !result_valid || (result_item.last == (result_item.kind != lsrd_pkg::KIND_DIST)), "last flag disagrees with kind")
  `LSRD_ASSERT_NEXT(a_timeout_fails, q_pop && (q_head.op == lsrd_pkg::OP_TIMEOUT) && (phase == lsrd_pkg::PH_RECORD), (phase == lsrd_pkg::PH_FAILED) && result_valid && (result_item.kind == lsrd_pkg::KIND_FAIL), "timeout in record did not fail the scan")

endmodule

>>> rtl/lidar_scan_response_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_response_decoder
// A result passes the queue and the registered result stage, after entries
// queued ahead of it. Throughput: one item per cycle while byte_stall is
// low; the back end retires one queue entry a cycle unless result_stall
// holds it. A two-entry queue between front and back absorbs output stalls.
// Reset (rst, synchronous): decoder idle, queue and result stage empty.
// ----------------------------------------------------------------------------
module lidar_scan_response_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  lsrd_pkg::in_item_t  byte_item,
  output logic                result_valid,
  input  logic                result_stall,
  output lsrd_pkg::out_item_t result_item
);

  logic             q_full;
  logic             q_push;
  logic             q_nonempty;
  logic             q_pop;
  lsrd_pkg::entry_t q_in;
  lsrd_pkg::entry_t q_head;

  lsrd_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  lsrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .pop        (q_pop),
    .head       (q_head)
  );

  lsrd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule
